// File: sv/cawf_pkg.sv
`default_nettype none

package cawf_pkg;

  // operation codes
  localparam logic [4:0] OP_ADD = 5'd0;
  localparam logic [4:0] OP_ADC = 5'd1;
  localparam logic [4:0] OP_SUB = 5'd2;
  localparam logic [4:0] OP_SBC = 5'd3;
  localparam logic [4:0] OP_AND = 5'd4;
  localparam logic [4:0] OP_XOR = 5'd5;
  localparam logic [4:0] OP_OR  = 5'd6;
  localparam logic [4:0] OP_CP  = 5'd7;
  localparam logic [4:0] OP_INC = 5'd8;
  localparam logic [4:0] OP_DEC = 5'd9;
  localparam logic [4:0] OP_RLC = 5'd10;
  localparam logic [4:0] OP_RRC = 5'd11;
  localparam logic [4:0] OP_RL  = 5'd12;
  localparam logic [4:0] OP_RR  = 5'd13;
  localparam logic [4:0] OP_SLA = 5'd14;
  localparam logic [4:0] OP_SRA = 5'd15;
  localparam logic [4:0] OP_SLL = 5'd16;
  localparam logic [4:0] OP_SRL = 5'd17;
  localparam logic [4:0] OP_DAA = 5'd18;
  localparam logic [4:0] OP_NEG = 5'd19;

  // flag bit positions
  localparam int FLG_C = 0;
  localparam int FLG_N = 1;
  localparam int FLG_P = 2;
  localparam int FLG_X = 3;
  localparam int FLG_H = 4;
  localparam int FLG_Y = 5;
  localparam int FLG_Z = 6;
  localparam int FLG_S = 7;

  // decimal adjust constants
  localparam logic [7:0] DAA_MAX    = 8'h99;
  localparam logic [7:0] DAA_HI_COR = 8'h60;
  localparam logic [7:0] DAA_LO_COR = 8'h06;
  localparam logic [3:0] DAA_LO_MAX = 4'd9;
  localparam logic [3:0] NIB_ALL    = 4'hF;
  localparam logic [7:0] INC_OVF    = 8'h80;
  localparam logic [7:0] DEC_OVF    = 8'h7F;

  typedef struct packed {
    logic [4:0] op;
    logic [7:0] acc;
    logic [7:0] operand;
    logic [7:0] flags_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result;
    logic [7:0] flags_out;
  } out_item_t;

endpackage

`default_nettype wire

// File: sv/cawf_alu.sv
`default_nettype none

module cawf_alu (
  input  wire cawf_pkg::in_item_t  item_i,
  output cawf_pkg::out_item_t      res_o
);

  // sign, zero, parity plus the copied y/x bits
  function automatic logic [7:0] szp(input logic [7:0] r);
    logic [7:0] f;
    f = 8'h00;
    f[cawf_pkg::FLG_S] = r[7];
    f[cawf_pkg::FLG_Y] = r[5];
    f[cawf_pkg::FLG_X] = r[3];
    f[cawf_pkg::FLG_Z] = (r == 8'h00);
    f[cawf_pkg::FLG_P] = ~(^r);
    return f;
  endfunction

  logic [7:0] a, v, f;
  logic       cin;
  logic [8:0] add_sum, sub_diff, neg_diff;
  logic [7:0] add_r, sub_r, neg_r;
  logic [7:0] add_f, sub_f, neg_f;
  logic [7:0] inc_r, dec_r;
  logic [7:0] daa_cor, daa_r;
  logic       daa_c;
  logic [7:0] r, nf;

  assign a   = item_i.acc;
  assign v   = item_i.operand;
  assign f   = item_i.flags_in;
  assign cin = f[cawf_pkg::FLG_C];

  // shared adder and subtractor; carry-in only used for adc/sbc
  always_comb begin
    logic c_use;
    c_use    = ((item_i.op == cawf_pkg::OP_ADC) || (item_i.op == cawf_pkg::OP_SBC)) ? cin : 1'b0;
    add_sum  = {1'b0, a} + {1'b0, v} + {8'h00, c_use};
    sub_diff = {1'b0, a} - {1'b0, v} - {8'h00, c_use};
    neg_diff = 9'h000 - {1'b0, a};
    add_r    = add_sum[7:0];
    sub_r    = sub_diff[7:0];
    neg_r    = neg_diff[7:0];

    add_f = szp(add_r);
    add_f[cawf_pkg::FLG_P] = (a[7] ~^ v[7]) & (a[7] ^ add_r[7]);
    add_f[cawf_pkg::FLG_H] = a[4] ^ v[4] ^ add_r[4];
    add_f[cawf_pkg::FLG_C] = add_sum[8];

    sub_f = szp(sub_r);
    sub_f[cawf_pkg::FLG_P] = (a[7] ^ v[7]) & (a[7] ^ sub_r[7]);
    sub_f[cawf_pkg::FLG_H] = a[4] ^ v[4] ^ sub_r[4];
    sub_f[cawf_pkg::FLG_N] = 1'b1;
    sub_f[cawf_pkg::FLG_C] = sub_diff[8];

    neg_f = szp(neg_r);
    neg_f[cawf_pkg::FLG_P] = a[7] & neg_r[7];
    neg_f[cawf_pkg::FLG_H] = a[4] ^ neg_r[4];
    neg_f[cawf_pkg::FLG_N] = 1'b1;
    neg_f[cawf_pkg::FLG_C] = neg_diff[8];
  end

  assign inc_r = v + 8'd1;
  assign dec_r = v - 8'd1;

  // decimal adjust correction
  always_comb begin
    daa_cor = 8'h00;
    daa_c   = cin;
    if (f[cawf_pkg::FLG_H] || (a[3:0] > cawf_pkg::DAA_LO_MAX)) begin
      daa_cor = daa_cor | cawf_pkg::DAA_LO_COR;
    end
    if (cin || (a > cawf_pkg::DAA_MAX)) begin
      daa_cor = daa_cor | cawf_pkg::DAA_HI_COR;
      daa_c   = 1'b1;
    end
    daa_r = f[cawf_pkg::FLG_N] ? (a - daa_cor) : (a + daa_cor);
  end

  always_comb begin
    r  = a;
    nf = f;
    unique case (item_i.op)
      cawf_pkg::OP_ADD, cawf_pkg::OP_ADC: begin
        r  = add_r;
        nf = add_f;
      end
      cawf_pkg::OP_SUB, cawf_pkg::OP_SBC: begin
        r  = sub_r;
        nf = sub_f;
      end
      cawf_pkg::OP_AND: begin
        r  = a & v;
        nf = szp(a & v);
        nf[cawf_pkg::FLG_H] = 1'b1;
      end
      cawf_pkg::OP_XOR: begin
        r  = a ^ v;
        nf = szp(a ^ v);
      end
      cawf_pkg::OP_OR: begin
        r  = a | v;
        nf = szp(a | v);
      end
      cawf_pkg::OP_CP: begin
        // y/x taken from the operand, not the difference
        r  = a;
        nf = sub_f;
        nf[cawf_pkg::FLG_Y] = v[5];
        nf[cawf_pkg::FLG_X] = v[3];
      end
      cawf_pkg::OP_INC: begin
        r  = inc_r;
        nf = szp(inc_r);
        nf[cawf_pkg::FLG_H] = (inc_r[3:0] == 4'h0);
        nf[cawf_pkg::FLG_P] = (inc_r == cawf_pkg::INC_OVF);
        nf[cawf_pkg::FLG_C] = cin;
      end
      cawf_pkg::OP_DEC: begin
        r  = dec_r;
        nf = szp(dec_r);
        nf[cawf_pkg::FLG_H] = (dec_r[3:0] == cawf_pkg::NIB_ALL);
        nf[cawf_pkg::FLG_P] = (dec_r == cawf_pkg::DEC_OVF);
        nf[cawf_pkg::FLG_N] = 1'b1;
        nf[cawf_pkg::FLG_C] = cin;
      end
      cawf_pkg::OP_RLC: begin
        r  = {v[6:0], v[7]};
        nf = szp({v[6:0], v[7]});
        nf[cawf_pkg::FLG_C] = v[7];
      end
      cawf_pkg::OP_RRC: begin
        r  = {v[0], v[7:1]};
        nf = szp({v[0], v[7:1]});
        nf[cawf_pkg::FLG_C] = v[0];
      end
      cawf_pkg::OP_RL: begin
        r  = {v[6:0], cin};
        nf = szp({v[6:0], cin});
        nf[cawf_pkg::FLG_C] = v[7];
      end
      cawf_pkg::OP_RR: begin
        r  = {cin, v[7:1]};
        nf = szp({cin, v[7:1]});
        nf[cawf_pkg::FLG_C] = v[0];
      end
      cawf_pkg::OP_SLA: begin
        r  = {v[6:0], 1'b0};
        nf = szp({v[6:0], 1'b0});
        nf[cawf_pkg::FLG_C] = v[7];
      end
      cawf_pkg::OP_SRA: begin
        r  = {v[7], v[7:1]};
        nf = szp({v[7], v[7:1]});
        nf[cawf_pkg::FLG_C] = v[0];
      end
      cawf_pkg::OP_SLL: begin
        r  = {v[6:0], 1'b1};
        nf = szp({v[6:0], 1'b1});
        nf[cawf_pkg::FLG_C] = v[7];
      end
      cawf_pkg::OP_SRL: begin
        r  = {1'b0, v[7:1]};
        nf = szp({1'b0, v[7:1]});
        nf[cawf_pkg::FLG_C] = v[0];
      end
      cawf_pkg::OP_DAA: begin
        r  = daa_r;
        nf = szp(daa_r);
        nf[cawf_pkg::FLG_H] = a[4] ^ daa_r[4];
        nf[cawf_pkg::FLG_N] = f[cawf_pkg::FLG_N];
        nf[cawf_pkg::FLG_C] = daa_c;
      end
      cawf_pkg::OP_NEG: begin
        r  = neg_r;
        nf = neg_f;
      end
      default: begin
        // unused codes pass acc and flags through
        r  = a;
        nf = f;
      end
    endcase
  end

  assign res_o.result    = r;
  assign res_o.flags_out = nf;

endmodule

`default_nettype wire

// File: sv/cpu_alu_with_flags_unit.sv
// channel   ports                          payload
// input     in_valid  in_ready  in_data    op acc operand flags_in
// result    out_valid out_ready out_data   result flags_out
//
// path: an accepted transaction is held in the input register, passes the alu
//   and is loaded into the result register, which drives out_valid
// throughput: one transaction per cycle while out_ready is not held low, set by
//   the single alu pass between the input register and the result register
// reset: rst_n synchronous active low, clears both valid bits only
// stalls: a held result stalls the input register, which then drops in_ready;
//   both stages move together as soon as out_ready returns
`default_nettype none

module cpu_alu_with_flags_unit (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire cawf_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output cawf_pkg::out_item_t      out_data
);

  // input register stage
  logic                 s1_valid_r, s1_valid_nxt;
  cawf_pkg::in_item_t   s1_data_r;

  // result register stage
  logic                 out_valid_r, out_valid_nxt;
  cawf_pkg::out_item_t  out_data_r;

  cawf_pkg::out_item_t  alu_res;
  logic                 out_take;   // result register can load this cycle
  logic                 s1_take;    // input register can load this cycle

  assign out_take = !out_valid_r || out_ready;
  assign s1_take  = !s1_valid_r || out_take;
  assign in_ready = s1_take;

  cawf_alu u_alu (
    .item_i (s1_data_r),
    .res_o  (alu_res)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_take) begin
      out_valid_nxt = s1_valid_r;
    end
    if (s1_take) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_data_r <= in_data;
    end
    if (out_take && s1_valid_r) begin
      out_data_r <= alu_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // a stalled input register keeps its transaction
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_take) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("input stage lost or changed a stalled transaction");

  // a transaction leaving the input register lands in the result register
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_take) |=> out_valid_r)
    else $error("transaction dropped between stages");

  // an accepted input transaction is held in the input register
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (s1_valid_r && (s1_data_r == $past(in_data))))
    else $error("accepted transaction not captured");

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("stages not empty after reset");
`endif

endmodule

`default_nettype wire

// File: tb/cpu_alu_with_flags_unit_tb.sv
`timescale 1ns / 1ps

module cpu_alu_with_flags_unit_tb;

  // expected result together with the request that caused it, for messages
  typedef struct packed {
    cawf_pkg::in_item_t  req;
    cawf_pkg::out_item_t want;
  } due_t;

  localparam int RANDOM_ITEMS = 1200;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  cawf_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  cawf_pkg::out_item_t out_data;

  cawf_pkg::in_item_t op_stream[$];    // requests waiting for the driver
  due_t               due_results[$];  // predictions waiting for the dut
  int       total_items = 0;
  int       accepted_cnt = 0;
  int       checked_cnt = 0;
  int       bcd_chains = 0;
  int       fail_cnt = 0;
  int       in_wait = 0;
  int       out_wait = 0;
  bit       in_calm = 1'b0;
  bit       out_calm = 1'b0;

  cpu_alu_with_flags_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // sign, zero, copies of bits 5 and 3, even parity; h n c left clear
  function automatic logic [7:0] szp_flags(logic [7:0] r);
    logic [7:0] f;
    f                  = '0;
    f[cawf_pkg::FLG_S] = r[7];
    f[cawf_pkg::FLG_Y] = r[5];
    f[cawf_pkg::FLG_X] = r[3];
    f[cawf_pkg::FLG_Z] = (r == 8'h00);
    f[cawf_pkg::FLG_P] = ~^r;
    return f;
  endfunction

  // 8-bit add or subtract with carry/borrow in; p/v carries the overflow
  function automatic cawf_pkg::out_item_t add_sub8(logic [7:0] a, logic [7:0] b,
                                                   logic cin, logic sub);
    logic [8:0]          s;
    cawf_pkg::out_item_t o;
    if (sub) begin
      s = {1'b0, a} - {1'b0, b} - {8'd0, cin};
    end else begin
      s = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    end
    o.result                     = s[7:0];
    o.flags_out                  = szp_flags(s[7:0]);
    o.flags_out[cawf_pkg::FLG_H] = a[4] ^ b[4] ^ s[4];
    // signed overflow: add when operand signs agree, sub when they differ,
    // and the result sign leaves the accumulator sign
    o.flags_out[cawf_pkg::FLG_P] = ((a[7] ~^ b[7]) ^ sub) & (a[7] ^ s[7]);
    o.flags_out[cawf_pkg::FLG_N] = sub;
    o.flags_out[cawf_pkg::FLG_C] = s[8];
    return o;
  endfunction

  function automatic cawf_pkg::out_item_t alu_eval(cawf_pkg::in_item_t t);
    logic [7:0]          a, v, f, r, corr;
    logic                cin, c;
    cawf_pkg::out_item_t o;
    a   = t.acc;
    v   = t.operand;
    f   = t.flags_in;
    cin = f[cawf_pkg::FLG_C];
    o.result    = a;
    o.flags_out = f;
    case (t.op)
      cawf_pkg::OP_ADD: o = add_sub8(a, v, 1'b0, 1'b0);
      cawf_pkg::OP_ADC: o = add_sub8(a, v, cin, 1'b0);
      cawf_pkg::OP_SUB: o = add_sub8(a, v, 1'b0, 1'b1);
      cawf_pkg::OP_SBC: o = add_sub8(a, v, cin, 1'b1);
      cawf_pkg::OP_AND: begin
        o.result                     = a & v;
        o.flags_out                  = szp_flags(a & v);
        o.flags_out[cawf_pkg::FLG_H] = 1'b1;
      end
      cawf_pkg::OP_XOR: begin
        o.result    = a ^ v;
        o.flags_out = szp_flags(a ^ v);
      end
      cawf_pkg::OP_OR: begin
        o.result    = a | v;
        o.flags_out = szp_flags(a | v);
      end
      cawf_pkg::OP_CP: begin
        // flags of a subtract, but y and x follow the operand
        o                            = add_sub8(a, v, 1'b0, 1'b1);
        o.result                     = a;
        o.flags_out[cawf_pkg::FLG_Y] = v[5];
        o.flags_out[cawf_pkg::FLG_X] = v[3];
      end
      cawf_pkg::OP_INC: begin
        r                            = v + 8'd1;
        o.result                     = r;
        o.flags_out                  = szp_flags(r);
        o.flags_out[cawf_pkg::FLG_P] = (r == cawf_pkg::INC_OVF);
        o.flags_out[cawf_pkg::FLG_H] = (r[3:0] == 4'h0);
        o.flags_out[cawf_pkg::FLG_C] = cin;
      end
      cawf_pkg::OP_DEC: begin
        r                            = v - 8'd1;
        o.result                     = r;
        o.flags_out                  = szp_flags(r);
        o.flags_out[cawf_pkg::FLG_P] = (r == cawf_pkg::DEC_OVF);
        o.flags_out[cawf_pkg::FLG_H] = (r[3:0] == cawf_pkg::NIB_ALL);
        o.flags_out[cawf_pkg::FLG_N] = 1'b1;
        o.flags_out[cawf_pkg::FLG_C] = cin;
      end
      cawf_pkg::OP_RLC, cawf_pkg::OP_RRC, cawf_pkg::OP_RL, cawf_pkg::OP_RR,
      cawf_pkg::OP_SLA, cawf_pkg::OP_SRA, cawf_pkg::OP_SLL, cawf_pkg::OP_SRL: begin
        case (t.op)
          cawf_pkg::OP_RLC: begin c = v[7]; r = {v[6:0], v[7]}; end
          cawf_pkg::OP_RRC: begin c = v[0]; r = {v[0], v[7:1]}; end
          cawf_pkg::OP_RL:  begin c = v[7]; r = {v[6:0], cin}; end
          cawf_pkg::OP_RR:  begin c = v[0]; r = {cin, v[7:1]}; end
          cawf_pkg::OP_SLA: begin c = v[7]; r = {v[6:0], 1'b0}; end
          cawf_pkg::OP_SRA: begin c = v[0]; r = {v[7], v[7:1]}; end
          cawf_pkg::OP_SLL: begin c = v[7]; r = {v[6:0], 1'b1}; end
          default:          begin c = v[0]; r = {1'b0, v[7:1]}; end
        endcase
        o.result                     = r;
        o.flags_out                  = szp_flags(r);
        o.flags_out[cawf_pkg::FLG_C] = c;
      end
      cawf_pkg::OP_DAA: begin
        corr = 8'h00;
        c    = cin;
        if (f[cawf_pkg::FLG_H] || (a[3:0] > cawf_pkg::DAA_LO_MAX)) begin
          corr = corr | cawf_pkg::DAA_LO_COR;
        end
        if (c || (a > cawf_pkg::DAA_MAX)) begin
          corr = corr | cawf_pkg::DAA_HI_COR;
          c    = 1'b1;
        end
        // n selects the direction of the last arithmetic op
        r                            = f[cawf_pkg::FLG_N] ? (a - corr) : (a + corr);
        o.result                     = r;
        o.flags_out                  = szp_flags(r);
        o.flags_out[cawf_pkg::FLG_H] = a[4] ^ r[4];
        o.flags_out[cawf_pkg::FLG_N] = f[cawf_pkg::FLG_N];
        o.flags_out[cawf_pkg::FLG_C] = c;
      end
      cawf_pkg::OP_NEG: o = add_sub8(8'h00, a, 1'b0, 1'b1);
      default: ;  // unused codes pass acc and flags through
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic cawf_pkg::in_item_t alu_req(logic [4:0] op, logic [7:0] a,
                                                 logic [7:0] v, logic [7:0] f);
    cawf_pkg::in_item_t t;
    t.op       = op;
    t.acc      = a;
    t.operand  = v;
    t.flags_in = f;
    return t;
  endfunction

  // byte with a bias toward the boundary values
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_bcd();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // per-item idle count; a calm stretch forces back-to-back transactions
  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one transaction at a time from op_stream
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back('{req: in_data, want: alu_eval(in_data)});
        accepted_cnt++;
      end
      // slot is free when nothing was offered or the offer was just taken
      if (!in_valid || in_ready) begin
        if (in_wait > 0) begin
          in_valid <= 1'b0;
          in_wait  <= in_wait - 1;
        end else if (op_stream.size() > 0) begin
          in_data  <= op_stream.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 29) == 0) in_calm = ~in_calm;
          in_wait  <= draw_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: stall the result side and compare each transaction in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    due_t d;
    int   gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result %02h flags %08b with no transaction outstanding",
                   $time, out_data.result, out_data.flags_out);
          fail_cnt++;
        end else begin
          d = due_results.pop_front();
          checked_cnt++;
          if (out_data.result !== d.want.result) begin
            $display("%0t: op %0d acc %02h opnd %02h flags %08b: result expected %02h got %02h",
                     $time, d.req.op, d.req.acc, d.req.operand, d.req.flags_in,
                     d.want.result, out_data.result);
            fail_cnt++;
          end
          if (out_data.flags_out !== d.want.flags_out) begin
            $display("%0t: op %0d acc %02h opnd %02h flags %08b: flags expected %08b got %08b",
                     $time, d.req.op, d.req.acc, d.req.operand, d.req.flags_in,
                     d.want.flags_out, out_data.flags_out);
            fail_cnt++;
          end
        end
        if ($urandom_range(0, 29) == 0) out_calm = ~out_calm;
        gap = draw_gap(out_calm);
        out_ready <= (gap == 0);
        out_wait  <= gap;
      end else if (!out_ready) begin
        // count down the stall, raise ready on its last cycle
        out_ready <= (out_wait <= 1);
        if (out_wait > 0) out_wait <= out_wait - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    cawf_pkg::in_item_t  first;
    cawf_pkg::out_item_t mid;
    int                  n;

    // directed: every op at its corner values
    op_stream.push_back(alu_req(cawf_pkg::OP_ADD, 8'hFF, 8'h01, 8'h00));  // zero, carry, half
    op_stream.push_back(alu_req(cawf_pkg::OP_ADC, 8'h7F, 8'h00, 8'h01));  // overflow, carry in
    op_stream.push_back(alu_req(cawf_pkg::OP_SUB, 8'h00, 8'h01, 8'hFF));  // borrow to ff
    op_stream.push_back(alu_req(cawf_pkg::OP_SBC, 8'h80, 8'h00, 8'h01));  // overflow, borrow in
    op_stream.push_back(alu_req(cawf_pkg::OP_AND, 8'hFF, 8'h00, 8'hFF));
    op_stream.push_back(alu_req(cawf_pkg::OP_XOR, 8'hAA, 8'h55, 8'h00));
    op_stream.push_back(alu_req(cawf_pkg::OP_OR, 8'h00, 8'h00, 8'hFF));
    op_stream.push_back(alu_req(cawf_pkg::OP_CP, 8'h10, 8'h28, 8'h00));  // y and x from operand
    op_stream.push_back(alu_req(cawf_pkg::OP_CP, 8'h28, 8'hD7, 8'hFF));  // acc bits 5, 3 ignored
    op_stream.push_back(alu_req(cawf_pkg::OP_INC, 8'hFF, 8'h7F, 8'h01));  // 7f to 80, carry kept
    op_stream.push_back(alu_req(cawf_pkg::OP_INC, 8'h00, 8'hFF, 8'h00));  // wrap to zero
    op_stream.push_back(alu_req(cawf_pkg::OP_DEC, 8'h00, 8'h80, 8'h00));  // 80 to 7f
    op_stream.push_back(alu_req(cawf_pkg::OP_DEC, 8'hFF, 8'h00, 8'h01));  // wrap to ff
    op_stream.push_back(alu_req(cawf_pkg::OP_RLC, 8'h00, 8'h80, 8'h00));
    op_stream.push_back(alu_req(cawf_pkg::OP_RRC, 8'h00, 8'h01, 8'h00));
    op_stream.push_back(alu_req(cawf_pkg::OP_RL, 8'h00, 8'h80, 8'h01));
    op_stream.push_back(alu_req(cawf_pkg::OP_RR, 8'h00, 8'h01, 8'h01));
    op_stream.push_back(alu_req(cawf_pkg::OP_SLA, 8'h00, 8'hFF, 8'h00));
    op_stream.push_back(alu_req(cawf_pkg::OP_SRA, 8'h00, 8'h80, 8'h00));
    op_stream.push_back(alu_req(cawf_pkg::OP_SLL, 8'h00, 8'h00, 8'h00));
    op_stream.push_back(alu_req(cawf_pkg::OP_SRL, 8'h00, 8'h01, 8'hFF));
    op_stream.push_back(alu_req(cawf_pkg::OP_DAA, 8'h9A, 8'h00, 8'h00));  // both nibbles
    op_stream.push_back(alu_req(cawf_pkg::OP_DAA, 8'h0F, 8'h00, 8'h12));  // subtract with half
    op_stream.push_back(alu_req(cawf_pkg::OP_NEG, 8'h80, 8'h00, 8'h00));  // overflow
    op_stream.push_back(alu_req(cawf_pkg::OP_NEG, 8'h00, 8'hFF, 8'hFF));  // zero, no borrow
    op_stream.push_back(alu_req(5'd31, 8'hA5, 8'h3C, 8'h5A));  // unused code passes through

    // random: plain ops, unused codes, and bcd add/sub followed by daa
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        first = alu_req(5'($urandom_range(cawf_pkg::OP_ADD, cawf_pkg::OP_SBC)),
                        pick_bcd(), pick_bcd(), 8'($urandom_range(0, 255)));
        mid   = alu_eval(first);
        op_stream.push_back(first);
        op_stream.push_back(alu_req(cawf_pkg::OP_DAA, mid.result,
                                    8'($urandom_range(0, 255)), mid.flags_out));
        bcd_chains++;
        n += 2;
      end else begin
        op_stream.push_back(alu_req(($urandom_range(0, 15) == 0) ?
                                    5'($urandom_range(20, 31)) :
                                    5'($urandom_range(cawf_pkg::OP_ADD, cawf_pkg::OP_NEG)),
                                    pick_byte(), pick_byte(), pick_byte()));
        n++;
      end
    end
    total_items = op_stream.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // sample on the falling edge so the driver and monitor have settled
    while (accepted_cnt < total_items) @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    // keep running to catch any stray result after the last one
    repeat (8) @(negedge clk);

    $display("%0d transactions checked: directed corners, %0d bcd add/sub+daa chains,",
             checked_cnt, bcd_chains);
    $display("random ops and unused codes under random stalls on both sides");
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #3_000_000;
    $display("timeout with %0d of %0d transactions accepted", accepted_cnt, total_items);
    $display("Test completed with failures");
    $finish;
  end

endmodule
